/* hdl/bfa_pkg.sv */
// shared types, constants and width helpers of the bitmap frame allocator
`default_nettype none
package bfa_pkg;

  localparam int ADDR_FIELD_W = 52;
  localparam int IN_TDATA_W   = 56;
  localparam int FRAME_ADDR_W = 27;
  localparam int FREE_CNT_W   = 16;
  localparam int STATUS_W     = 3;
  localparam int OUT_TDATA_W  = 48;
  localparam int MAP_WORD_W   = 64;
  localparam int MAP_BIT_W    = 6;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC      = 3'd0,
    ST_NONE       = 3'd1,
    ST_FREED      = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_RANGE      = 3'd4,
    ST_RESERVED   = 3'd5,
    ST_ALREADY    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REJECT = 2'd2
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } cmd_ctrl_t;

  localparam int CMD_CTRL_W = $bits(cmd_ctrl_t);

  function automatic int res_limit(int total, int reserved);
    return (reserved > total) ? total : reserved;
  endfunction

  function automatic int map_words(int total);
    return (total + MAP_WORD_W - 1) / MAP_WORD_W;
  endfunction

  function automatic int word_addr_w(int total);
    return (map_words(total) > 1) ? $clog2(map_words(total)) : 1;
  endfunction

  function automatic int frame_idx_w(int total);
    return word_addr_w(total) + MAP_BIT_W;
  endfunction

endpackage
`default_nettype wire

/* hdl/bitmap_frame_allocator_core.sv */
// top level of the bitmap frame allocator
//
// channel  dir  tdata                                     tuser
// s_axis   in   [51:0] address, [55:52] zero              [0] mode (0 allocate, 1 free)
// m_axis   out  [26:0] frame_address, [42:27] free_frames [2:0] status
//
// free requests pass the free-check and response states, rejected ones skip the check
// allocate reads map words from the lowest word that may still hold a free frame,
//   passing over full words; map words are 64 frames wide
// after reset a clearing pass writes ceil(TOTAL_FRAMES/64) words,
//   with s_axis_tready_o low
// a two-entry queue keeps taking requests while a result waits on m_axis
`default_nettype none
module bitmap_frame_allocator_core import bfa_pkg::*; #(
  parameter int TOTAL_FRAMES    = 32768,
  parameter int RESERVED_FRAMES = 768,
  parameter int FRAME_SIZE_LOG2 = 12,
  parameter int ADDRESS_BITS    = 52
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // address, pad
  input  wire logic                   s_axis_tuser_i,  // mode
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,  // frame_address, free_frames, pad
  output logic [STATUS_W-1:0]         m_axis_tuser_o   // status
);

  localparam int IdxW = frame_idx_w(TOTAL_FRAMES);
  localparam int QW   = CMD_CTRL_W + IdxW;

  logic                    map_ready;
  logic                    q_full;
  logic                    q_valid;
  logic                    push;
  logic                    pop;
  cmd_ctrl_t               push_ctrl;
  logic [IdxW-1:0]         push_idx;
  logic [QW-1:0]           head;
  cmd_ctrl_t               head_ctrl;
  logic [FRAME_ADDR_W-1:0] frame_address;
  logic [FREE_CNT_W-1:0]   free_frames;

  bfa_front #(
    .TOTAL_FRAMES    (TOTAL_FRAMES),
    .RESERVED_FRAMES (RESERVED_FRAMES),
    .FRAME_SIZE_LOG2 (FRAME_SIZE_LOG2),
    .ADDRESS_BITS    (ADDRESS_BITS),
    .IDX_W           (IdxW)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .room_i          (map_ready & ~q_full),
    .push_o          (push),
    .ctrl_o          (push_ctrl),
    .idx_o           (push_idx)
  );

  bfa_queue #(
    .DW (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctrl, push_idx}),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  assign head_ctrl = head[QW-1:IdxW];

  bfa_back #(
    .TOTAL_FRAMES    (TOTAL_FRAMES),
    .RESERVED_FRAMES (RESERVED_FRAMES),
    .FRAME_SIZE_LOG2 (FRAME_SIZE_LOG2),
    .IDX_W           (IdxW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .map_ready_o     (map_ready),
    .cmd_valid_i     (q_valid),
    .cmd_ctrl_i      (head_ctrl),
    .cmd_idx_i       (head[IdxW-1:0]),
    .cmd_pop_o       (pop),
    .res_valid_o     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .frame_address_o (frame_address),
    .status_o        (m_axis_tuser_o),
    .free_frames_o   (free_frames)
  );

  assign m_axis_tdata_o = {
    (OUT_TDATA_W - FRAME_ADDR_W - FREE_CNT_W)'(0), free_frames, frame_address
  };

endmodule
`default_nettype wire

/* hdl/bfa_front.sv */
// request front end: accepts requests and checks free addresses
`default_nettype none
module bfa_front import bfa_pkg::*; #(
  parameter int TOTAL_FRAMES    = 32768,
  parameter int RESERVED_FRAMES = 768,
  parameter int FRAME_SIZE_LOG2 = 12,
  parameter int ADDRESS_BITS    = 52,
  parameter int IDX_W           = 15
) (
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,
  input  wire logic                  room_i,
  output logic                       push_o,
  output cmd_ctrl_t                  ctrl_o,
  output logic [IDX_W-1:0]           idx_o
);

  localparam int ResLim = res_limit(TOTAL_FRAMES, RESERVED_FRAMES);

  logic [ADDR_FIELD_W-1:0] addr_m;
  logic [ADDR_FIELD_W-1:0] idx_full;
  logic                    misaligned;
  logic                    out_of_range;
  logic                    in_reserved;

  always_comb begin
    misaligned = 1'b0;
    for (int k = 0; k < ADDR_FIELD_W; k++) begin
      addr_m[k] = s_axis_tdata_i[k] & (k < ADDRESS_BITS);
    end
    for (int k = 0; k < FRAME_SIZE_LOG2; k++) begin
      misaligned = misaligned | addr_m[k];
    end
  end

  assign idx_full     = addr_m >> FRAME_SIZE_LOG2;
  assign out_of_range = idx_full >= ADDR_FIELD_W'(TOTAL_FRAMES);
  assign in_reserved  = idx_full < ADDR_FIELD_W'(ResLim);

  always_comb begin
    ctrl_o.op     = OP_REJECT;
    ctrl_o.status = ST_MISALIGNED;
    if (s_axis_tuser_i == MODE_ALLOC) begin
      ctrl_o.op     = OP_ALLOC;
      ctrl_o.status = ST_ALLOC;
    end else if (misaligned) begin
      ctrl_o.status = ST_MISALIGNED;
    end else if (out_of_range) begin
      ctrl_o.status = ST_RANGE;
    end else if (in_reserved) begin
      ctrl_o.status = ST_RESERVED;
    end else begin
      ctrl_o.op     = OP_FREE;
      ctrl_o.status = ST_FREED;
    end
  end

  assign idx_o           = IDX_W'(idx_full);
  assign s_axis_tready_o = room_i;
  assign push_o          = s_axis_tvalid_i & room_i;

endmodule
`default_nettype wire

/* hdl/bfa_queue.sv */
// two-entry command queue between front end and map engine
`default_nettype none
module bfa_queue import bfa_pkg::*; #(
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output logic [DW-1:0]      head_o
);

  logic [DW-1:0] slot_q [2];
  logic          wp_q, wp_d;
  logic          rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = slot_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wp_d  = wp_q ^ do_push;
    rp_d  = rp_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/bfa_back.sv */
// map engine: frame bitmap memory, clearing pass, first-fit scan and result register
`default_nettype none
module bfa_back import bfa_pkg::*; #(
  parameter int TOTAL_FRAMES    = 32768,
  parameter int RESERVED_FRAMES = 768,
  parameter int FRAME_SIZE_LOG2 = 12,
  parameter int IDX_W           = 15
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  output logic                         map_ready_o,
  input  wire logic                    cmd_valid_i,
  input  wire cmd_ctrl_t               cmd_ctrl_i,
  input  wire logic [IDX_W-1:0]        cmd_idx_i,
  output logic                         cmd_pop_o,
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output logic [FRAME_ADDR_W-1:0]      frame_address_o,
  output logic [STATUS_W-1:0]          status_o,
  output logic [FREE_CNT_W-1:0]        free_frames_o
);

  localparam int ResLim    = res_limit(TOTAL_FRAMES, RESERVED_FRAMES);
  localparam int NumWords  = map_words(TOTAL_FRAMES);
  localparam int WaW       = IDX_W - MAP_BIT_W;
  localparam int CntW      = $clog2(TOTAL_FRAMES + 1);
  localparam int HintRst   = (ResLim / MAP_WORD_W >= NumWords) ? 0 : ResLim / MAP_WORD_W;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ASCAN = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [MAP_WORD_W-1:0] map_mem [NumWords];
  logic [MAP_WORD_W-1:0] rd_word_q;
  logic                  mem_we;
  logic [WaW-1:0]        mem_wa, mem_ra;
  logic [MAP_WORD_W-1:0] mem_wd;

  logic [2:0]            state_q, state_d;
  logic [WaW-1:0]        clr_q, clr_d;
  logic [WaW-1:0]        hint_q, hint_d;
  logic [WaW-1:0]        word_q, word_d;
  logic [MAP_BIT_W-1:0]  bit_q, bit_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  status_e               res_status_q, res_status_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;

  logic                  out_valid_q;
  logic [FRAME_ADDR_W-1:0] out_addr_q;
  status_e               out_status_q;
  logic [FREE_CNT_W-1:0] out_cnt_q;
  logic                  out_load;

  logic [MAP_WORD_W-1:0] init_word;
  logic [IDX_W:0]        init_idx;
  logic [2:0]            byte_sel;
  logic [2:0]            bit_sel;
  logic [7:0]            sel_byte;
  logic [MAP_BIT_W-1:0]  zero_pos;
  logic                  word_full;

  logic [IDX_W+FRAME_SIZE_LOG2+FRAME_ADDR_W-1:0] addr_ext;
  logic [CntW+FREE_CNT_W-1:0]                    cnt_ext;

  // reset pattern: reserved frames and padding past the last frame are used
  always_comb begin
    init_idx = '0;
    for (int j = 0; j < MAP_WORD_W; j++) begin
      init_idx     = {1'b0, clr_q, MAP_BIT_W'(j)};
      init_word[j] = (init_idx < (IDX_W+1)'(ResLim)) ||
                     (init_idx >= (IDX_W+1)'(TOTAL_FRAMES));
    end
  end

  // lowest clear bit of the word read, byte first then bit
  always_comb begin
    byte_sel = '0;
    bit_sel  = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!(&rd_word_q[8*k +: 8])) begin
        byte_sel = 3'(k);
      end
    end
    sel_byte = rd_word_q[8*byte_sel +: 8];
    for (int k = 7; k >= 0; k--) begin
      if (!sel_byte[k]) begin
        bit_sel = 3'(k);
      end
    end
    zero_pos  = {byte_sel, bit_sel};
    word_full = &rd_word_q;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hint_d       = hint_q;
    word_d       = word_q;
    bit_d        = bit_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    mem_wa       = word_q;
    mem_wd       = rd_word_q;
    mem_ra       = '0;
    cmd_pop_o    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = init_word;
        clr_d  = clr_q + 1'b1;
        if (clr_q == WaW'(NumWords - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          res_idx_d = '0;
          unique case (cmd_ctrl_i.op)
            OP_ALLOC: begin
              if (cnt_q == '0) begin
                res_status_d = ST_NONE;
                state_d      = S_RESP;
              end else begin
                mem_ra  = hint_q;
                word_d  = hint_q;
                state_d = S_ASCAN;
              end
            end
            OP_FREE: begin
              mem_ra  = cmd_idx_i[IDX_W-1:MAP_BIT_W];
              word_d  = cmd_idx_i[IDX_W-1:MAP_BIT_W];
              bit_d   = cmd_idx_i[MAP_BIT_W-1:0];
              state_d = S_FCHK;
            end
            default: begin
              res_status_d = cmd_ctrl_i.status;
              state_d      = S_RESP;
            end
          endcase
        end
      end
      S_ASCAN: begin
        if (word_full) begin
          word_d = word_q + 1'b1;
          hint_d = word_q + 1'b1;
          mem_ra = word_q + 1'b1;
        end else begin
          mem_we           = 1'b1;
          mem_wd           = rd_word_q;
          mem_wd[zero_pos] = 1'b1;
          hint_d           = word_q;
          cnt_d            = cnt_q - 1'b1;
          res_status_d     = ST_ALLOC;
          res_idx_d        = {word_q, zero_pos};
          state_d          = S_RESP;
        end
      end
      S_FCHK: begin
        if (!rd_word_q[bit_q]) begin
          res_status_d = ST_ALREADY;
        end else begin
          mem_we        = 1'b1;
          mem_wd        = rd_word_q;
          mem_wd[bit_q] = 1'b0;
          cnt_d         = cnt_q + 1'b1;
          if (word_q < hint_q) begin
            hint_d = word_q;
          end
          res_status_d = ST_FREED;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_word_q <= map_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      clr_q        <= '0;
      hint_q       <= WaW'(HintRst);
      cnt_q        <= CntW'(TOTAL_FRAMES - ResLim);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign addr_ext = {FRAME_ADDR_W'(0), res_idx_q, FRAME_SIZE_LOG2'(0)};
  assign cnt_ext  = {FREE_CNT_W'(0), cnt_q};

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    bit_q        <= bit_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_addr_q   <= addr_ext[FRAME_ADDR_W-1:0];
      out_status_q <= res_status_q;
      out_cnt_q    <= cnt_ext[FREE_CNT_W-1:0];
    end
  end

  assign map_ready_o     = state_q != S_INIT;
  assign res_valid_o     = out_valid_q;
  assign frame_address_o = out_addr_q;
  assign status_o        = out_status_q;
  assign free_frames_o   = out_cnt_q;

endmodule
`default_nettype wire

/* hdl/bfa_checker.sv */
// port-level checks of the bitmap frame allocator and their bind
`default_nettype none
module bfa_checker import bfa_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [STATUS_W-1:0]    m_axis_tuser_o
);

  logic                    out_hs;
  logic                    seen_q;
  logic [FREE_CNT_W-1:0]   last_cnt_q;
  logic [FREE_CNT_W-1:0]   exp_cnt;
  logic [FRAME_ADDR_W-1:0] f_addr;
  logic [FREE_CNT_W-1:0]   f_cnt;
  logic                    is_free_status;
  logic                    in_hs;

  assign out_hs = m_axis_tvalid_o & m_axis_tready_i;
  assign in_hs  = s_axis_tvalid_i & s_axis_tready_o;
  assign f_addr = m_axis_tdata_o[FRAME_ADDR_W-1:0];
  assign f_cnt  = m_axis_tdata_o[FRAME_ADDR_W +: FREE_CNT_W];
  assign is_free_status = (m_axis_tuser_o == ST_FREED) || (m_axis_tuser_o == ST_MISALIGNED) ||
                          (m_axis_tuser_o == ST_RANGE) || (m_axis_tuser_o == ST_RESERVED) ||
                          (m_axis_tuser_o == ST_ALREADY);

  always_comb begin
    exp_cnt = last_cnt_q;
    if (m_axis_tuser_o == ST_ALLOC) begin
      exp_cnt = last_cnt_q - 1'b1;
    end else if (m_axis_tuser_o == ST_FREED) begin
      exp_cnt = last_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (out_hs) begin
      seen_q     <= 1'b1;
      last_cnt_q <= f_cnt;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result request dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_NONE) |-> (f_addr == '0) && (f_cnt == '0))
    else $error("no-frame result with address or free count set");

  a_free_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_free_status |-> f_addr == '0)
    else $error("free result carries a frame address");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && seen_q && !in_hs |-> f_cnt == exp_cnt)
    else $error("free count moved by the wrong step");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (.*);
`default_nettype wire
